// ----- rtl/u2u8_pkg.sv -----
// Package for the UTF-16 to UTF-8 encoder.
// Holds the transfer job type, field widths and the BMP byte encoder.
// No dependencies.
package u2u8_pkg;

    localparam int UNIT_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int JOB_BYTES    = 6;
    localparam int CNT_W        = 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;
    localparam logic [4:0] HI_SURR_TOP = 5'b11011;

    localparam logic [7:0] LEAD1 = 8'h00;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [JOB_BYTES-1:0][BYTE_W-1:0] seq;
        logic [CNT_W-1:0]                 count;
        logic                             str_end;
    } job_t;

    typedef struct packed {
        logic [2:0][BYTE_W-1:0] b;
        logic [1:0]             n;
    } bmp_enc_t;

    function automatic bmp_enc_t enc_bmp(input logic [UNIT_W-1:0] c);
        bmp_enc_t r;
        r = '0;
        if (c[15:7] == 9'd0)
        begin
            r.b[0] = LEAD1 | {1'b0, c[6:0]};
            r.n    = 2'd1;
        end
        else if (c[15:11] == 5'd0)
        begin
            r.b[0] = LEAD2 | {3'b000, c[10:6]};
            r.b[1] = CONT | {2'b00, c[5:0]};
            r.n    = 2'd2;
        end
        else
        begin
            r.b[0] = LEAD3 | {4'b0000, c[15:12]};
            r.b[1] = CONT | {2'b00, c[11:6]};
            r.b[2] = CONT | {2'b00, c[5:0]};
            r.n    = 2'd3;
        end
        return r;
    endfunction

endpackage

// ----- rtl/u2u8_front.sv -----
// Front end: accepts code units, pairs surrogates and builds byte jobs.
// Depends on u2u8_pkg.
module u2u8_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [u2u8_pkg::UNIT_W-1:0]     code_unit,
    input  logic                            last_unit,
    output logic                            job_push,
    output u2u8_pkg::job_t                  job
);
    import u2u8_pkg::*;

    logic        held_valid_reg, held_valid_next;
    logic [9:0]  held_bits_reg, held_bits_next;
    logic        is_hi, is_lo, new_en;
    logic [4:0]  plane;
    bmp_enc_t    flush_enc, new_enc;

    assign is_hi  = code_unit[15:10] == HI_SURR_TAG;
    assign is_lo  = code_unit[15:10] == LO_SURR_TAG;
    assign new_en = !(is_hi && !last_unit);
    assign plane  = {1'b0, held_bits_reg[9:6]} + 5'd1;

    always_comb
    begin
        flush_enc = enc_bmp({HI_SURR_TOP, 1'b0, held_bits_reg});
        new_enc   = enc_bmp(code_unit);
    end

    always_comb
    begin
        job             = '0;
        job.str_end     = last_unit;
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (held_valid_reg && is_lo)
        begin
            job.seq[0]      = LEAD4 | {5'd0, plane[4:2]};
            job.seq[1]      = CONT | {2'b00, plane[1:0], held_bits_reg[5:2]};
            job.seq[2]      = CONT | {2'b00, held_bits_reg[1:0], code_unit[9:6]};
            job.seq[3]      = CONT | {2'b00, code_unit[5:0]};
            job.count       = 3'd4;
            held_valid_next = 1'b0;
            held_bits_next  = '0;
        end
        else
        begin
            if (held_valid_reg)
            begin
                job.seq[0] = flush_enc.b[0];
                job.seq[1] = flush_enc.b[1];
                job.seq[2] = flush_enc.b[2];
                job.count  = 3'd3;
                if (new_en)
                begin
                    job.seq[3] = new_enc.b[0];
                    job.seq[4] = new_enc.b[1];
                    job.seq[5] = new_enc.b[2];
                    job.count  = 3'd3 + {1'b0, new_enc.n};
                end
            end
            else if (new_en)
            begin
                job.seq[0] = new_enc.b[0];
                job.seq[1] = new_enc.b[1];
                job.seq[2] = new_enc.b[2];
                job.count  = {1'b0, new_enc.n};
            end
            held_valid_next = !new_en;
            held_bits_next  = new_en ? 10'd0 : code_unit[9:0];
        end
    end

    assign job_push = accept && (job.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else if (accept)
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

    a_end_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_unit |=> !held_valid_reg)
        else $error("surrogate still held after end of string");

    a_silent_only_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !job_push |=> held_valid_reg && !$past(held_valid_reg))
        else $error("unit produced no bytes without being held");

endmodule

// ----- rtl/u2u8_queue.sv -----
// Job queue between the front end and the byte serialiser.
// Depends on u2u8_pkg.
module u2u8_queue #(
    parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2u8_pkg::job_t  push_job,
    input  logic            pop,
    output u2u8_pkg::job_t  head,
    output logic            full,
    output logic            empty
);
    import u2u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t                entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]   fill_reg;

    assign full  = fill_reg == CNT_QW'(DEPTH);
    assign empty = fill_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

endmodule

// ----- rtl/u2u8_back.sv -----
// Back end: serialises queued jobs into UTF-8 bytes through an output register.
// Depends on u2u8_pkg.
module u2u8_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  u2u8_pkg::job_t                  head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]     out_byte,
    output logic                            run_last,
    output logic                            string_end
);
    import u2u8_pkg::*;

    logic [CNT_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg, string_end_reg;
    logic              load, at_last;

    assign load    = !empty && (!out_valid_reg || out_ready);
    assign at_last = idx_reg == (head.count - 3'd1);
    assign pop     = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= head.seq[idx_reg];
            run_last_reg   <= at_last;
            string_end_reg <= at_last && head.str_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = string_end_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> idx_reg < head.count)
        else $error("byte index past end of job");

    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end without run end");

endmodule

// ----- rtl/utf16_to_utf8_encoder.sv -----
// Top level of the UTF-16 to UTF-8 encoder.
// Depends on u2u8_pkg, u2u8_front, u2u8_queue and u2u8_back.
//
// Input channel: code_unit and last_unit, transferred when in_valid and
// in_ready are both high. Output channel: out_byte, run_last and string_end,
// transferred when out_valid and out_ready are both high.
// A high surrogate that is not the last unit is held until the next unit;
// a pair gives four bytes, other units one to three, a flushed one three more.
// The front end turns each unit into a job of up to six bytes in the same
// cycle and pushes it into a QUEUE_DEPTH-entry job queue. The back end sends
// one byte per cycle while the receiver is ready, from the queue head through
// an output register, so the first byte of a unit passes through the queue
// entry and then the output register before it appears; the single output
// byte lane sets the sustained rate.
// in_ready drops only while the job queue is full; the front end keeps
// accepting while the output register waits on a stalled receiver.
// Reset empties the queue, clears the held surrogate and the output valid.
module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [u2u8_pkg::UNIT_W-1:0]     code_unit,
    input  logic                            last_unit,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]     out_byte,
    output logic                            run_last,
    output logic                            string_end
);
    import u2u8_pkg::*;

    job_t  job, head;
    logic  job_push, pop, full, empty, accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    u2u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .job_push  (job_push),
        .job       (job)
    );

    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule
